### hw/rtl/odo_pkg.sv
// Shared constants, types and the arctangent table for the odometry block.
package odo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CNT_W        = $clog2(CORDIC_STEPS + 1);
  localparam int CW           = 44;  // CORDIC x/y datapath width
  localparam int ZW           = 33;  // CORDIC angle accumulator width

  localparam logic [31:0] LEFT_STEP_RESET  = 32'd4154039;
  localparam logic [31:0] RIGHT_STEP_RESET = 32'd4154039;
  localparam logic [19:0] HALF_TRACK_RESET = 20'd53120;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 44'sd652032874;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [1:0] REG_LEFT_STEP  = 2'd0;
  localparam logic [1:0] REG_RIGHT_STEP = 2'd1;
  localparam logic [1:0] REG_HALF_TRACK = 2'd2;

  typedef struct packed {
    logic start;
    logic vector;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/odo_mul.sv
// Shared signed 33x33 multiplier with registered product.
module odo_mul
  import odo_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic        [63:0] p
);

  logic signed [65:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full[63:0];
  end

endmodule

### hw/rtl/odo_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
module odo_cordic
  import odo_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cordic_ctl_t          ctl,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output logic                 done,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic signed [ZW-1:0] z
);

  logic             busy;
  logic             vec_mode;
  logic [CNT_W-1:0] cnt;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic             plus;

  assign xs   = x >>> cnt;
  assign ys   = y >>> cnt;
  assign at   = $signed({1'b0, atan_lut(5'(cnt))});
  // rotate toward zero residual: by z sign when rotating, by y sign when vectoring
  assign plus = vec_mode ? y[CW-1] : ~z[ZW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy     <= 1'b1;
        vec_mode <= ctl.vector;
        cnt      <= '0;
        x        <= x0;
        y        <= y0;
        z        <= z0;
      end else if (busy) begin
        if (cnt == CNT_W'(CORDIC_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
          if (plus) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
        end
      end
    end
  end

endmodule

### hw/rtl/differential_drive_odometry.sv
// Differential-drive odometry top level: sequencer, pose state and output register.
//
// Dead-reckoning odometry. Each request carries absolute left/right encoder
// counts; the block forms wrapped 32-bit deltas, scales them by the per-wheel
// step lengths (2^-24 mm per count), turns the heading by
// atan((tl/2 - tr/2) / (half_track << 16)) and advances X/Y by the mean travel
// times cos/sin of the new heading. Positions are 48-bit Q.16 mm and wrap;
// heading is a 32-bit binary angle. One request is processed at a time and
// in_ready is high only while the sequencer is idle. When the halved travels
// are equal or the track term is zero, normalize and the vectoring pass are
// skipped; otherwise the atan operands first get 0..24 one-bit normalize
// shifts. The block uses the single CORDIC unit (one micro-rotation per cycle,
// used for vectoring then rotation) and one shared 33x33 multiplier that does
// the two wheel scalings and the four partial products of the X/Y increments.
// A finished result sits in the output register until taken; the next request
// can be accepted while it waits, and that request stalls in its last step
// until the register frees. Config writes (cfg_we/cfg_index/cfg_data)
// take effect at once and should only be made while idle; index 3 is ignored.
module differential_drive_odometry
  import odo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [31:0] heading
);

  typedef enum logic [3:0] {
    S_IDLE, S_ML, S_MR, S_MWAIT, S_HY, S_NORM, S_VEC, S_ROTS, S_ROT,
    S_X0, S_X1, S_X2, S_Y1, S_Y2, S_DONE
  } state_t;

  state_t state;

  // config
  logic [31:0] left_step, right_step;
  logic [19:0] half_track;

  // pose
  logic [31:0] last_left, last_right, angle_acc;
  logic [47:0] x_acc, y_acc;

  // per-request working registers
  logic [31:0]        dlc, drc;
  logic signed [63:0] dl, dr, mean;
  logic [63:0]        ny, nx;
  logic               hneg, flip;
  logic [31:0]        ca, sa;
  logic               cneg, sneg;
  logic [63:0]        plo;

  // shared units
  logic signed [32:0] ma_op, mb_op;
  logic [63:0]        prod;
  cordic_ctl_t        cctl;
  logic signed [CW-1:0] cx0, cy0, cx, cy;
  logic signed [ZW-1:0] cz0, cz;
  logic               cdone;

  // combinational helpers
  logic signed [63:0] hy, mean_c;
  logic [63:0]        ym, xm, mmax, ma;
  logic               norm_ok;
  logic               flip_c;
  logic [31:0]        rot_a;
  logic signed [CW-1:0] cfin, sfin, cabs, sabs;
  logic [95:0]        psum;
  logic [47:0]        inc;

  odo_mul u_mul (
    .clk (clk),
    .a   (ma_op),
    .b   (mb_op),
    .p   (prod)
  );

  odo_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .ctl  (cctl),
    .x0   (cx0),
    .y0   (cy0),
    .z0   (cz0),
    .done (cdone),
    .x    (cx),
    .y    (cy),
    .z    (cz)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    hy     = (dl >>> 1) - (dr >>> 1);
    mean_c = (dl >>> 1) + (dr >>> 1) + $signed(64'(dl[0] & dr[0]));
    ym     = hy[63] ? (64'd0 - 64'(hy)) : 64'(hy);
    xm     = {28'd0, half_track, 16'd0};
    mmax   = (ny > nx) ? ny : nx;
    norm_ok = (mmax[63:40] == '0) && mmax[39];
    ma     = mean[63] ? (64'd0 - 64'(mean)) : 64'(mean);
    // fold angles beyond +-90 degrees by a half turn
    flip_c = angle_acc[31] ^ angle_acc[30];
    rot_a  = {angle_acc[31] ^ flip_c, angle_acc[30:0]};
    cfin   = flip ? -cx : cx;
    sfin   = flip ? -cy : cy;
    cabs   = cfin[CW-1] ? -cfin : cfin;
    sabs   = sfin[CW-1] ? -sfin : sfin;
    psum   = {32'd0, plo} + {prod, 32'd0};
    inc    = psum[85:38];
  end

  // multiplier operand select
  always_comb begin
    case (state)
      S_ML:    begin ma_op = {dlc[31], dlc};        mb_op = {1'b0, left_step};  end
      S_MR:    begin ma_op = {drc[31], drc};        mb_op = {1'b0, right_step}; end
      S_X0:    begin ma_op = {1'b0, ma[31:0]};      mb_op = {1'b0, ca};         end
      S_X1:    begin ma_op = {1'b0, ma[63:32]};     mb_op = {1'b0, ca};         end
      S_X2:    begin ma_op = {1'b0, ma[31:0]};      mb_op = {1'b0, sa};         end
      S_Y1:    begin ma_op = {1'b0, ma[63:32]};     mb_op = {1'b0, sa};         end
      default: begin ma_op = '0;                    mb_op = '0;                 end
    endcase
  end

  // CORDIC launch: vectoring on normalized operands, then rotation from gain
  always_comb begin
    cctl.vector = (state == S_NORM);
    cctl.start  = ((state == S_NORM) && norm_ok) || (state == S_ROTS);
    if (state == S_NORM) begin
      cx0 = {4'd0, nx[39:0]};
      cy0 = {4'd0, ny[39:0]};
      cz0 = '0;
    end else begin
      cx0 = CORDIC_GAIN;
      cy0 = '0;
      cz0 = {rot_a[31], rot_a};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      left_step  <= LEFT_STEP_RESET;
      right_step <= RIGHT_STEP_RESET;
      half_track <= HALF_TRACK_RESET;
      last_left  <= '0;
      last_right <= '0;
      angle_acc  <= '0;
      x_acc      <= '0;
      y_acc      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_STEP:  left_step  <= cfg_data;
          REG_RIGHT_STEP: right_step <= cfg_data;
          REG_HALF_TRACK: half_track <= cfg_data[19:0];
          default: ;
        endcase
      end

      // S_DONE reloads the output register itself
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            dlc        <= left_count - last_left;
            drc        <= right_count - last_right;
            last_left  <= left_count;
            last_right <= right_count;
            state      <= S_ML;
          end
        end
        S_ML:    state <= S_MR;
        S_MR: begin
          dl    <= prod;
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          dr    <= prod;
          state <= S_HY;
        end
        S_HY: begin
          mean <= mean_c;
          hneg <= hy[63];
          ny   <= ym;
          nx   <= xm;
          if (ym == '0) begin
            state <= S_ROTS;            // equal travels: no turn
          end else if (xm == '0) begin
            // zero track: exact quarter turn
            angle_acc <= hy[63] ? angle_acc + QUARTER_TURN : angle_acc - QUARTER_TURN;
            state     <= S_ROTS;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (mmax[63:40] != '0) begin
            ny <= ny >> 1;
            nx <= nx >> 1;
          end else if (!mmax[39]) begin
            ny <= ny << 1;
            nx <= nx << 1;
          end else begin
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (cdone) begin
            angle_acc <= hneg ? angle_acc + cz[31:0] : angle_acc - cz[31:0];
            state     <= S_ROTS;
          end
        end
        S_ROTS: begin
          flip  <= flip_c;
          state <= S_ROT;
        end
        S_ROT: begin
          if (cdone) begin
            ca    <= cabs[31:0];
            sa    <= sabs[31:0];
            cneg  <= cfin[CW-1];
            sneg  <= sfin[CW-1];
            state <= S_X0;
          end
        end
        S_X0:    state <= S_X1;
        S_X1: begin
          plo   <= prod;
          state <= S_X2;
        end
        S_X2: begin
          x_acc <= (mean[63] != cneg) ? x_acc - inc : x_acc + inc;
          state <= S_Y1;
        end
        S_Y1: begin
          plo   <= prod;
          state <= S_Y2;
        end
        S_Y2: begin
          y_acc <= (mean[63] != sneg) ? y_acc - inc : y_acc + inc;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            pos_x     <= x_acc;
            pos_y     <= y_acc;
            heading   <= angle_acc;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cdone |-> (state == S_VEC || state == S_ROT))
    else $error("CORDIC finished outside a wait state");

  a_heading_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (heading == angle_acc))
    else $error("published heading differs from pose");

  a_norm_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_VEC) |-> (nx[63:40] == '0 && ny[63:40] == '0))
    else $error("vectoring operands out of range");
`endif

endmodule

### dv/odometry_checker.sv
// Checker: watches the request and result channels, predicts the pose and compares.
module odometry_checker
  import odo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [47:0] pos_x,
  input  logic signed [47:0] pos_y,
  input  logic signed [31:0] heading,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [47:0] x;
    logic [47:0] y;
    logic [31:0] hd;
  } pose_t;

  // Tables are kept locally; only constants come from the package.
  logic [31:0] arc_tab [32];
  initial begin
    arc_tab = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
                32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
                32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
                32'h00000000, 32'h00000000};
  end

  logic [31:0] step_l, step_r;
  logic [19:0] track;
  logic [31:0] prev_l, prev_r, ang;
  logic [47:0] px, py;
  pose_t       pose_q[$];

  function automatic logic [31:0] atan_of(input logic [63:0] ym_in, input logic [63:0] xm_in);
    logic [63:0] ym, xm, m;
    logic signed [63:0] xv, yv, nx, z;
    ym = ym_in; xm = xm_in; z = 0;
    if (ym == 0) return 32'd0;
    if (xm == 0) return QUARTER_TURN;
    m = (ym > xm) ? ym : xm;
    while (m >= (64'd1 << 40)) begin ym >>= 1; xm >>= 1; m >>= 1; end
    while (m < (64'd1 << 39)) begin ym <<= 1; xm <<= 1; m <<= 1; end
    xv = xm; yv = ym;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (yv >= 0) begin
        nx = xv + (yv >>> i); yv = yv - (xv >>> i); z = z + arc_tab[i];
      end else begin
        nx = xv - (yv >>> i); yv = yv + (xv >>> i); z = z - arc_tab[i];
      end
      xv = nx;
    end
    return z[31:0];
  endfunction

  task automatic cos_sin(input logic [31:0] a_in, output logic signed [63:0] c,
                         output logic signed [63:0] s);
    logic [31:0] a;
    logic flip;
    logic signed [63:0] xv, yv, z, nx;
    a = a_in;
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    z = $signed(a); xv = 652032874; yv = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = xv - (yv >>> i); yv = yv + (xv >>> i); z = z - arc_tab[i];
      end else begin
        nx = xv + (yv >>> i); yv = yv - (xv >>> i); z = z + arc_tab[i];
      end
      xv = nx;
    end
    c = flip ? -xv : xv;
    s = flip ? -yv : yv;
  endtask

  function automatic logic [63:0] travel_step(input logic signed [63:0] mean,
                                              input logic signed [63:0] f);
    logic [63:0] ma;
    logic [31:0] fa;
    logic [127:0] prod;
    logic [63:0] mag;
    ma = (mean < 0) ? -mean : mean;
    fa = 32'((f < 0) ? -f : f);
    prod = ma * fa;
    mag = prod[101:38];
    return ((mean < 0) != (f < 0)) ? -mag : mag;
  endfunction

  task automatic advance_pose(input logic [31:0] lc, input logic [31:0] rc);
    logic signed [63:0] dl, dr, hy, mean, c, s;
    logic [63:0] ym;
    logic [31:0] dz, d32;
    pose_t p;
    d32 = lc - prev_l; dl = $signed(d32) * $signed({32'd0, step_l});
    d32 = rc - prev_r; dr = $signed(d32) * $signed({32'd0, step_r});
    prev_l = lc; prev_r = rc;
    hy = (dl >>> 1) - (dr >>> 1);
    ym = (hy < 0) ? -hy : hy;
    dz = atan_of(ym, {28'd0, track, 16'd0});
    if (hy < 0) dz = -dz;
    ang = ang - dz;
    mean = (dl >>> 1) + (dr >>> 1) + $signed({63'd0, dl[0] & dr[0]});
    cos_sin(ang, c, s);
    px = px + 48'(travel_step(mean, c));
    py = py + 48'(travel_step(mean, s));
    p.x = px; p.y = py; p.hd = ang;
    pose_q.push_back(p);
  endtask

  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      step_l <= LEFT_STEP_RESET; step_r <= RIGHT_STEP_RESET; track <= HALF_TRACK_RESET;
      prev_l = 0; prev_r = 0; ang = 0; px = 0; py = 0;
      pose_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h hd=%h", $time, pos_x, pos_y, heading);
          fail_count <= fail_count + 1;
        end else begin
          e = pose_q.pop_front();
          if (e.x !== pos_x || e.y !== pos_y || e.hd !== heading) begin
            $display("%0t: mismatch exp x=%h y=%h hd=%h got x=%h y=%h hd=%h",
                     $time, e.x, e.y, e.hd, pos_x, pos_y, heading);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) advance_pose(left_count, right_count);
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_STEP:  step_l <= cfg_data;
          REG_RIGHT_STEP: step_r <= cfg_data;
          REG_HALF_TRACK: track  <= cfg_data[19:0];
          default: ;
        endcase
      end
    end
    pending = pose_q.size();
  end

endmodule

### dv/differential_drive_odometry_test.sv
// Testbench top: stimulus, config phases and verdict for the odometry block.
module differential_drive_odometry_test;
  import odo_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_LEFT_STEP;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] left_count = 0, right_count = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [47:0] pos_x, pos_y;
  logic signed [31:0] heading;
  int fail_count, pending;
  int cycles = 0;
  int accepted = 0;
  int results = 0;
  bit hold_off = 0;   // long receiver stall, driven by the stimulus process

  localparam int LIMIT = 2_000_000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  always #2 clk = ~clk;

  differential_drive_odometry u_dut (.*);

  odometry_checker u_chk (.*);

  // Absolute counts the stimulus tracks so it can choose deltas.
  logic [31:0] cur_l = 0, cur_r = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) if (out_valid && out_ready) results <= results + 1;

  // Receiver: random stall per result, plus the long hold-off window.
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      if (hold_off) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else if (w > 0) begin
        out_ready <= 0;
      end
      repeat (w) @(posedge clk);
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // valid stays high into the next request when it has no idle gap
  task automatic send_request(input logic [31:0] l, input logic [31:0] r);
    int w;
    w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1; left_count <= l; right_count <= r;
    cur_l = l; cur_r = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted++;
  endtask

  // Delta-based request: mostly small realistic motion, sometimes full range.
  task automatic random_request();
    logic [31:0] dl, dr;
    case ($urandom_range(0, 7))
      0: begin dl = $urandom; dr = $urandom; end
      1: begin dl = $urandom_range(0, 2000) - 1000; dr = dl; end
      2: begin dl = $urandom_range(0, 200) - 100; dr = -dl; end
      3: begin dl = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
               dr = $urandom; end
      default: begin dl = $urandom_range(0, 4000) - 2000;
                     dr = dl + $urandom_range(0, 60) - 30; end
    endcase
    send_request(cur_l + dl, cur_r + dr);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, equal travels (zero turn), pure spins.
    send_request(32'h0, 32'h0);
    send_request(32'h7fffffff, 32'h7fffffff);
    send_request(32'h80000000, 32'h80000000);
    send_request(32'hffffffff, 32'h0);
    send_request(32'h0, 32'hffffffff);
    send_request(32'h7fffffff, 32'h80000000);
    send_request(32'h80000000, 32'h7fffffff);
    send_request(32'h100, 32'h50);
    send_request(32'h100, 32'h200);
    send_request(32'haaaaaaaa, 32'h55555555);
    send_request(32'h55555555, 32'haaaaaaaa);
    wait_idle();

    // Register extremes, including the ignored index.
    write_reg(REG_LEFT_STEP, 32'hffffffff);
    write_reg(REG_RIGHT_STEP, 32'h0);
    write_reg(REG_HALF_TRACK, 32'h1);
    write_reg(REG_UNUSED, 32'h12345678);
    for (int i = 0; i < 6; i++) random_request();
    wait_idle();
    write_reg(REG_LEFT_STEP, 32'h0);
    write_reg(REG_RIGHT_STEP, 32'hffffffff);
    write_reg(REG_HALF_TRACK, 32'hfffff);
    for (int i = 0; i < 6; i++) random_request();
    wait_idle();

    // Random phases across varied settings; one phase runs under receiver stall.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        write_reg(REG_LEFT_STEP, LEFT_STEP_RESET);
        write_reg(REG_RIGHT_STEP, RIGHT_STEP_RESET);
        write_reg(REG_HALF_TRACK, HALF_TRACK_RESET);
      end else begin
        write_reg(REG_LEFT_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1<<24));
        write_reg(REG_RIGHT_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1<<24));
        write_reg(REG_HALF_TRACK, $urandom_range(1, 20'hfffff));
      end
      if (ph == 2) hold_off = 1;
      for (int i = 0; i < 250; i++) random_request();
      wait_idle();
    end

    $display("covered %0d requests, %0d results, over eight register settings", accepted, results);
    $display("including extreme counts, step lengths, track widths and a long output stall");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
